FILE: hw/rtl/moving_average_crossover_signal_defines.svh
// Assertion macros for the checker file of the crossover signal block.
`ifndef MOVING_AVERAGE_CROSSOVER_SIGNAL_DEFINES_SVH
`define MOVING_AVERAGE_CROSSOVER_SIGNAL_DEFINES_SVH

// Checked at every rising clock edge while reset is low.
`define MACS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every rising clock edge, reset included.
`define MACS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/macs_pkg.sv
// Shared constants, register codes and control types of the crossover signal block.
`default_nettype none

package macs_pkg;

   localparam int SUM_BITS       = 32;
   localparam int SIGNAL_BITS    = 19;
   localparam int LEN_BITS       = 9;
   localparam int WEIGHT_BITS    = 16;
   localparam int SAMPLE_IN_BITS = 24;
   localparam int SAMPLE_MAX_BITS = 32;
   localparam int MAX_AVERAGES   = 4;
   localparam int REQ_TDATA_BITS = 24;
   localparam int RSP_FIELD_BITS = SIGNAL_BITS + MAX_AVERAGES * SUM_BITS;
   localparam int RSP_TDATA_BITS = 152;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_FIELD_BITS;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic [LEN_BITS-1:0]    len_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;

   typedef enum logic [2:0] {
      CSR_LEN_0    = 3'd0,
      CSR_LEN_1    = 3'd1,
      CSR_LEN_2    = 3'd2,
      CSR_LEN_3    = 3'd3,
      CSR_WEIGHT_0 = 3'd4,
      CSR_WEIGHT_1 = 3'd5,
      CSR_WEIGHT_2 = 3'd6,
      CSR_WEIGHT_3 = 3'd7
   } csr_index_type;

   localparam len_type LEN_RESET [MAX_AVERAGES] = '{9'd200, 9'd100, 9'd50, 9'd20};
   localparam weight_type WEIGHT_RESET = 16'd1;

   // Pipeline control that the top level hands to every cell.
   typedef struct packed {
      logic accept;      // beat taken: ring written, old sample read
      logic advance;     // beat moves from the sum stage to the compare stage
      logic commit;      // beat moves from the compare stage to the output register
      logic primed;      // compare-stage beat is primed
      logic was_primed;  // block was primed before the compare-stage beat
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/moving_average_crossover_signal.sv
// Top level of the moving-average crossover signal block: registers, control and cell row.
//
//   channel  direction  handshake                 payload
//   req      in         req_tvalid / req_tready   sample
//   rsp      out        rsp_tvalid / rsp_tready   signal, sums; primed in tuser
//   csr      in         APB write, read           len_0..3, weight_0..3
//
// One beat is taken every cycle while the stages ahead can move on; a result reaches
// rsp through the registered ring read in each cell, the compare stage and the output register.
// Reset is synchronous; the ring needs no clearing pass, since the
// fill count masks entries that were never written.
// A stalled rsp holds its beat, and req keeps taking beats until the two
// internal stages behind the output register are full.
`default_nettype none

module moving_average_crossover_signal #(
   parameter int RING_DEPTH   = 256,
   parameter int NUM_AVERAGES = 4,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [macs_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [macs_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [macs_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: sample [23:0]
   input  logic [macs_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata: signal [18:0], sum_0 [50:19], sum_1 [82:51], sum_2 [114:83],
   //        sum_3 [146:115], zero fill [151:147]
   output logic [macs_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   // tuser: primed [0]
   output logic                                   rsp_tuser
);

   localparam int ADDR_BITS = $clog2(RING_DEPTH);
   localparam int FILL_BITS = $clog2(RING_DEPTH + 1);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(RING_DEPTH - 1);
   localparam logic [FILL_BITS-1:0] FULL_FILL = FILL_BITS'(RING_DEPTH);

   macs_pkg::len_type    len_ff    [macs_pkg::MAX_AVERAGES];
   macs_pkg::weight_type weight_ff [macs_pkg::MAX_AVERAGES];

   logic                                csr_we;
   logic [2:0]                          csr_index;
   logic [macs_pkg::SAMPLE_MAX_BITS-1:0] sample_wide;
   logic [SAMPLE_BITS-1:0]              sample_a;
   logic [ADDR_BITS-1:0]                wr_addr_ff;
   logic [ADDR_BITS-1:0]                wr_addr_in;
   logic [FILL_BITS-1:0]                fill_ff;
   logic [FILL_BITS-1:0]                fill_in;
   logic                                was_primed_a;
   logic                                primed_a;

   logic                                o_free;
   logic                                commit;
   logic                                c_free;
   logic                                advance;
   logic                                b_free;
   logic                                accept;

   logic                                b_valid_ff;
   logic                                c_valid_ff;
   logic                                rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]              b_sample_ff;
   logic                                b_primed_ff;
   logic                                b_was_ff;
   logic                                c_primed_ff;
   logic                                c_was_ff;

   logic [macs_pkg::SIGNAL_BITS-1:0]    rsp_signal_ff;
   logic                                rsp_primed_ff;
   logic [macs_pkg::SUM_BITS-1:0]       rsp_sum_ff [macs_pkg::MAX_AVERAGES];

   macs_pkg::cell_ctrl_type             cell_ctrl;
   logic [macs_pkg::SIGNAL_BITS-1:0]    sig_chain [NUM_AVERAGES + 1];
   logic [FILL_BITS-1:0]                cell_len  [NUM_AVERAGES];
   logic [macs_pkg::SUM_BITS-1:0]       cell_sum  [macs_pkg::MAX_AVERAGES];

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[macs_pkg::CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < macs_pkg::MAX_AVERAGES; k++) begin
            len_ff[k]    <= macs_pkg::LEN_RESET[k];
            weight_ff[k] <= macs_pkg::WEIGHT_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            macs_pkg::CSR_LEN_0:    len_ff[0]    <= csr_pwdata[macs_pkg::LEN_BITS-1:0];
            macs_pkg::CSR_LEN_1:    len_ff[1]    <= csr_pwdata[macs_pkg::LEN_BITS-1:0];
            macs_pkg::CSR_LEN_2:    len_ff[2]    <= csr_pwdata[macs_pkg::LEN_BITS-1:0];
            macs_pkg::CSR_LEN_3:    len_ff[3]    <= csr_pwdata[macs_pkg::LEN_BITS-1:0];
            macs_pkg::CSR_WEIGHT_0: weight_ff[0] <= csr_pwdata[macs_pkg::WEIGHT_BITS-1:0];
            macs_pkg::CSR_WEIGHT_1: weight_ff[1] <= csr_pwdata[macs_pkg::WEIGHT_BITS-1:0];
            macs_pkg::CSR_WEIGHT_2: weight_ff[2] <= csr_pwdata[macs_pkg::WEIGHT_BITS-1:0];
            macs_pkg::CSR_WEIGHT_3: weight_ff[3] <= csr_pwdata[macs_pkg::WEIGHT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         macs_pkg::CSR_LEN_0:    csr_prdata = macs_pkg::CSR_DATA_BITS'(len_ff[0]);
         macs_pkg::CSR_LEN_1:    csr_prdata = macs_pkg::CSR_DATA_BITS'(len_ff[1]);
         macs_pkg::CSR_LEN_2:    csr_prdata = macs_pkg::CSR_DATA_BITS'(len_ff[2]);
         macs_pkg::CSR_LEN_3:    csr_prdata = macs_pkg::CSR_DATA_BITS'(len_ff[3]);
         macs_pkg::CSR_WEIGHT_0: csr_prdata = macs_pkg::CSR_DATA_BITS'(weight_ff[0]);
         macs_pkg::CSR_WEIGHT_1: csr_prdata = macs_pkg::CSR_DATA_BITS'(weight_ff[1]);
         macs_pkg::CSR_WEIGHT_2: csr_prdata = macs_pkg::CSR_DATA_BITS'(weight_ff[2]);
         macs_pkg::CSR_WEIGHT_3: csr_prdata = macs_pkg::CSR_DATA_BITS'(weight_ff[3]);
         default:                csr_prdata = '0;
      endcase
   end

   // Each stage moves on when the stage after it is empty or moving itself.
   always_comb begin
      o_free     = !rsp_valid_ff || rsp_tready;
      commit     = c_valid_ff && o_free;
      c_free     = !c_valid_ff || commit;
      advance    = b_valid_ff && c_free;
      b_free     = !b_valid_ff || advance;
      req_tready = b_free;
      accept     = req_tvalid && b_free;
   end

   always_comb begin
      sample_wide  = macs_pkg::SAMPLE_MAX_BITS'(req_tdata);
      sample_a     = sample_wide[SAMPLE_BITS-1:0];
      wr_addr_in   = (wr_addr_ff == LAST_ADDR) ? '0 : wr_addr_ff + ADDR_BITS'(1);
      fill_in      = (fill_ff == FULL_FILL) ? fill_ff : fill_ff + FILL_BITS'(1);
      was_primed_a = fill_ff >= cell_len[0];
      primed_a     = fill_in >= cell_len[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_addr_ff   <= '0;
         fill_ff      <= '0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            wr_addr_ff <= wr_addr_in;
            fill_ff    <= fill_in;
         end
         if (accept) begin
            b_valid_ff <= 1'b1;
         end else if (advance) begin
            b_valid_ff <= 1'b0;
         end
         if (advance) begin
            c_valid_ff <= 1'b1;
         end else if (commit) begin
            c_valid_ff <= 1'b0;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_sample_ff <= sample_a;
         b_primed_ff <= primed_a;
         b_was_ff    <= was_primed_a;
      end
      if (advance) begin
         c_primed_ff <= b_primed_ff;
         c_was_ff    <= b_was_ff;
      end
      if (commit) begin
         rsp_signal_ff <= sig_chain[NUM_AVERAGES];
         rsp_primed_ff <= c_primed_ff;
         for (int k = 0; k < macs_pkg::MAX_AVERAGES; k++) begin
            rsp_sum_ff[k] <= cell_sum[k];
         end
      end
   end

   always_comb begin
      cell_ctrl.accept     = accept;
      cell_ctrl.advance    = advance;
      cell_ctrl.commit     = commit;
      cell_ctrl.primed     = c_primed_ff;
      cell_ctrl.was_primed = c_was_ff;
   end

   // The partial signal runs along the row, each cell adding its crossing.
   assign sig_chain[0] = '0;

   for (genvar k = 0; k < macs_pkg::MAX_AVERAGES; k++) begin : g_cell
      if (k < NUM_AVERAGES) begin : g_used
         macs_cell #(
            .RING_DEPTH  (RING_DEPTH),
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .sample     (sample_a),
            .sample_b   (b_sample_ff),
            .wr_addr    (wr_addr_ff),
            .fill_count (fill_ff),
            .len_cfg    (len_ff[k]),
            .weight     (weight_ff[k]),
            .signal_in  (sig_chain[k]),
            .signal_out (sig_chain[k+1]),
            .eff_len    (cell_len[k]),
            .sum        (cell_sum[k])
         );
      end else begin : g_unused
         assign cell_sum[k] = '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_primed_ff;
   assign rsp_tdata  = {{macs_pkg::RSP_PAD_BITS{1'b0}},
                        rsp_sum_ff[3], rsp_sum_ff[2], rsp_sum_ff[1], rsp_sum_ff[0],
                        rsp_signal_ff};

endmodule

`default_nettype wire

FILE: hw/rtl/macs_cell.sv
// One averaging cell: ring copy, running window sum, crossing flag and signal stage.
`default_nettype none

module macs_cell #(
   parameter int RING_DEPTH  = 256,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  macs_pkg::cell_ctrl_type             ctrl,
   input  logic [SAMPLE_BITS-1:0]              sample,
   input  logic [SAMPLE_BITS-1:0]              sample_b,
   input  logic [$clog2(RING_DEPTH)-1:0]       wr_addr,
   input  logic [$clog2(RING_DEPTH+1)-1:0]     fill_count,
   input  macs_pkg::len_type                   len_cfg,
   input  macs_pkg::weight_type                weight,
   input  logic [macs_pkg::SIGNAL_BITS-1:0]    signal_in,
   output logic [macs_pkg::SIGNAL_BITS-1:0]    signal_out,
   output logic [$clog2(RING_DEPTH+1)-1:0]     eff_len,
   output logic [macs_pkg::SUM_BITS-1:0]       sum
);

   localparam int ADDR_BITS = $clog2(RING_DEPTH);
   localparam int FILL_BITS = $clog2(RING_DEPTH + 1);
   localparam int EXT_BITS  = (FILL_BITS > macs_pkg::LEN_BITS) ? FILL_BITS : macs_pkg::LEN_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + FILL_BITS;
   localparam int CMP_BITS  = (PROD_BITS > macs_pkg::SUM_BITS) ? PROD_BITS : macs_pkg::SUM_BITS;
   localparam logic [EXT_BITS-1:0]  DEPTH_EXT  = EXT_BITS'(RING_DEPTH);
   localparam logic [ADDR_BITS:0]   DEPTH_ADDR = (ADDR_BITS + 1)'(RING_DEPTH);

   logic [EXT_BITS-1:0]              len_ext;
   logic [ADDR_BITS:0]               back_pos;
   logic [ADDR_BITS-1:0]             rd_addr;
   logic [SAMPLE_BITS-1:0]           ring_mem [RING_DEPTH];
   logic [SAMPLE_BITS-1:0]           old_ff;
   logic                             old_valid_ff;
   logic [macs_pkg::SUM_BITS-1:0]    old_term;
   logic [macs_pkg::SUM_BITS-1:0]    sum_ff;
   logic [macs_pkg::SUM_BITS-1:0]    sum_in;
   logic [PROD_BITS-1:0]             scaled_ff;
   logic [PROD_BITS-1:0]             scaled_in;
   logic [CMP_BITS-1:0]              scaled_cmp;
   logic [CMP_BITS-1:0]              sum_cmp;
   logic                             above;
   logic                             below;
   logic                             steady;
   logic                             rise;
   logic                             fall;
   logic                             above_ff;
   logic                             above_in;
   logic [macs_pkg::SIGNAL_BITS-1:0] weight_ext;

   // A length of zero counts as one, and one beyond the ring as the whole ring.
   always_comb begin
      len_ext = EXT_BITS'(len_cfg);
      if (len_ext == '0) begin
         len_ext = EXT_BITS'(1);
      end else if (len_ext > DEPTH_EXT) begin
         len_ext = DEPTH_EXT;
      end
      eff_len = len_ext[FILL_BITS-1:0];
   end

   always_comb begin
      back_pos = {1'b0, wr_addr} + DEPTH_ADDR - (ADDR_BITS + 1)'(eff_len);
      if (back_pos >= DEPTH_ADDR) begin
         back_pos = back_pos - DEPTH_ADDR;
      end
      rd_addr = back_pos[ADDR_BITS-1:0];
   end

   // The ring is written in order from entry zero, so an entry lying further
   // back than the fill count has never been written and counts as zero.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         ring_mem[wr_addr] <= sample;
         old_ff            <= ring_mem[rd_addr];
         old_valid_ff      <= (fill_count >= eff_len);
      end
   end

   always_comb begin
      old_term  = old_valid_ff ? macs_pkg::SUM_BITS'(old_ff) : '0;
      sum_in    = sum_ff + macs_pkg::SUM_BITS'(sample_b) - old_term;
      scaled_in = PROD_BITS'(sample_b) * PROD_BITS'(eff_len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.advance) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         scaled_ff <= scaled_in;
      end
   end

   always_comb begin
      scaled_cmp = CMP_BITS'(scaled_ff);
      sum_cmp    = CMP_BITS'(sum_ff);
      above      = scaled_cmp > sum_cmp;
      below      = scaled_cmp < sum_cmp;
      steady     = ctrl.primed && ctrl.was_primed;
      rise       = steady && !above_ff && above;
      fall       = steady && above_ff && below;
      weight_ext = macs_pkg::SIGNAL_BITS'(weight);
      if (rise) begin
         signal_out = signal_in + weight_ext;
      end else if (fall) begin
         signal_out = signal_in - weight_ext;
      end else begin
         signal_out = signal_in;
      end
      // On the priming beat the flag simply takes the present comparison.
      if (ctrl.primed && !ctrl.was_primed) begin
         above_in = above;
      end else if (rise) begin
         above_in = 1'b1;
      end else if (fall) begin
         above_in = 1'b0;
      end else begin
         above_in = above_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff <= 1'b0;
      end else if (ctrl.commit) begin
         above_ff <= above_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/macs_checker.sv
// Port-level checker of the crossover signal block and its bind to the top level.
`default_nettype none

`include "moving_average_crossover_signal_defines.svh"

module macs_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [macs_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input wire logic                                rsp_tuser
);

   // Straight after reset the output is empty and a beat can be taken.
   `MACS_ASSERT_ALWAYS(a_reset_state, $past(reset) |-> !rsp_tvalid && req_tready, "bad state after reset")

   // The input side only stalls while a finished result is being held back.
   `MACS_ASSERT(a_stall_cause, !req_tready |-> rsp_tvalid && !rsp_tready, "input stalled without output stall")

   // No crossing can be reported before the block is primed.
   `MACS_ASSERT(a_unprimed_signal, rsp_tvalid && !rsp_tuser |-> rsp_tdata[macs_pkg::SIGNAL_BITS-1:0] == '0, "signal before priming")

   `MACS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind moving_average_crossover_signal macs_checker u_macs_checker (.*);

`default_nettype wire

FILE: bench/crossover_scoreboard_pkg.sv
// Scoreboard for the crossover signal block: window-sum predictor and result comparison.
package crossover_scoreboard_pkg;
   import macs_pkg::*;

   localparam int RING_ENTRIES = 256;
   localparam int AVERAGES     = 4;

   typedef struct packed {
      logic [AVERAGES-1:0][SUM_BITS-1:0] sums;
      logic                              primed;
      logic [SIGNAL_BITS-1:0]            signal;
   } crossover_beat;

   class crossover_scoreboard;
      len_type                   len_reg    [AVERAGES];
      weight_type                weight_reg [AVERAGES];
      logic [SAMPLE_IN_BITS-1:0] price_ring [RING_ENTRIES];
      logic [7:0]                write_ptr;
      logic [8:0]                sample_count;
      logic [SUM_BITS-1:0]       window_sum [AVERAGES];
      bit                        above      [AVERAGES];
      crossover_beat             pending_results [$];
      int                        results_seen;
      int                        failures;

      function new();
         foreach (price_ring[i]) price_ring[i] = '0;
         foreach (window_sum[k]) begin
            window_sum[k] = '0;
            above[k]      = 1'b0;
            len_reg[k]    = LEN_RESET[k];
            weight_reg[k] = WEIGHT_RESET;
         end
         write_ptr    = '0;
         sample_count = '0;
         results_seen = 0;
         failures     = 0;
      endfunction

      function void set_register(csr_index_type index, logic [CSR_DATA_BITS-1:0] value);
         if (index <= CSR_LEN_3) begin
            len_reg[int'(index) - int'(CSR_LEN_0)] = value[LEN_BITS-1:0];
         end else begin
            weight_reg[int'(index) - int'(CSR_WEIGHT_0)] = value[WEIGHT_BITS-1:0];
         end
      endfunction

      function logic [CSR_DATA_BITS-1:0] register_value(csr_index_type index);
         if (index <= CSR_LEN_3) begin
            return CSR_DATA_BITS'(len_reg[int'(index) - int'(CSR_LEN_0)]);
         end
         return CSR_DATA_BITS'(weight_reg[int'(index) - int'(CSR_WEIGHT_0)]);
      endfunction

      // A length of zero behaves as one, anything past the ring depth as the full ring.
      function logic [8:0] window_length(int k);
         logic [8:0] n;
         n = len_reg[k];
         if (n == 9'd0) n = 9'd1;
         if (n > 9'(RING_ENTRIES)) n = 9'(RING_ENTRIES);
         return n;
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("result %0d: %s expected %h, got %h", results_seen, what, want, got);
            end
         end
      endfunction

      function void take_sample(logic [SAMPLE_IN_BITS-1:0] sample);
         crossover_beat beat;
         logic [7:0]    slot;
         logic [8:0]    span;
         logic [63:0]   scaled;
         bit            was_primed;
         int            crossings;
         was_primed = sample_count >= window_length(0);
         // Every window drops the sample that lies its length back before the slot is reused.
         for (int k = 0; k < AVERAGES; k++) begin
            span = window_length(k);
            slot = write_ptr - span[7:0];
            window_sum[k] = window_sum[k] + SUM_BITS'(sample) - SUM_BITS'(price_ring[slot]);
         end
         price_ring[write_ptr] = sample;
         write_ptr = write_ptr + 8'd1;
         if (sample_count < 9'(RING_ENTRIES)) sample_count = sample_count + 9'd1;
         beat.primed = sample_count >= window_length(0);
         crossings = 0;
         if (beat.primed) begin
            for (int k = 0; k < AVERAGES; k++) begin
               scaled = 64'(sample) * 64'(window_length(k));
               if (!was_primed) begin
                  above[k] = scaled > 64'(window_sum[k]);
               end else if (above[k] && scaled < 64'(window_sum[k])) begin
                  crossings -= int'(weight_reg[k]);
                  above[k] = 1'b0;
               end else if (!above[k] && scaled > 64'(window_sum[k])) begin
                  crossings += int'(weight_reg[k]);
                  above[k] = 1'b1;
               end
            end
         end
         beat.signal = crossings[SIGNAL_BITS-1:0];
         for (int k = 0; k < AVERAGES; k++) beat.sums[k] = window_sum[k];
         pending_results.push_back(beat);
      endfunction

      function void check_result(logic [RSP_TDATA_BITS-1:0] data, logic user);
         crossover_beat beat;
         results_seen++;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("result %0d arrived with nothing pending: tdata %h tuser %b",
                        results_seen, data, user);
            end
            return;
         end
         beat = pending_results.pop_front();
         compare_field("signal", 32'(beat.signal), 32'(data[SIGNAL_BITS-1:0]));
         compare_field("primed", 32'(beat.primed), 32'(user));
         for (int k = 0; k < AVERAGES; k++) begin
            compare_field($sformatf("sum_%0d", k), beat.sums[k],
                          data[SIGNAL_BITS + k*SUM_BITS +: SUM_BITS]);
         end
         compare_field("zero fill", 32'd0, 32'(data[RSP_TDATA_BITS-1:RSP_FIELD_BITS]));
      endfunction
   endclass

endpackage

FILE: bench/testbench.sv
// Top-level testbench for the crossover signal block: drivers, monitor, watchdog and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import macs_pkg::*;
   import crossover_scoreboard_pkg::*;

   localparam int CLOCK_PERIOD     = 20;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 8;
   localparam logic [SAMPLE_IN_BITS-1:0] SAMPLE_TOP = '1;
   localparam logic [SAMPLE_IN_BITS-1:0] OPENING_RUN [20] = '{
      24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000,
      24'hFFFFFF, 24'h000000, 24'h800000, 24'h800000, 24'h800000,
      24'h800000, 24'hAAAAAA, 24'h555555, 24'hFFFFFE, 24'h000001,
      24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h123456, 24'h000000};

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]      csr_paddr;
   logic [CSR_DATA_BITS-1:0]      csr_pwdata;
   logic [CSR_DATA_BITS-1:0]      csr_prdata;
   logic                          csr_pready;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [REQ_TDATA_BITS-1:0]     req_tdata;    // sample [23:0]
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   // signal [18:0], sum_0 [50:19], sum_1 [82:51], sum_2 [114:83], sum_3 [146:115], zero fill
   logic [RSP_TDATA_BITS-1:0]     rsp_tdata;
   logic                          rsp_tuser;    // primed [0]

   crossover_scoreboard sb;
   bit                  quiet     = 1'b0;
   bit                  long_hold = 1'b0;
   int                  price     = 'h800000;
   int                  swing     = 2048;
   int unsigned         cycle_count = 0;

   moving_average_crossover_signal uut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.take_sample(req_tdata[SAMPLE_IN_BITS-1:0]);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Result side: short random stalls, and one long hold-off on request.
   initial begin : result_side
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // psel is left high between back-to-back transfers and lowered by the caller.
   task automatic csr_access(input logic write, input csr_index_type index,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel   <= 1'b1;
      csr_pwrite <= write;
      csr_paddr  <= CSR_ADDR_BITS'(4 * int'(index));
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(input csr_index_type index, input int value);
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [CSR_DATA_BITS-1:0] readback;
      // The bits above the register's width are junk that it has to drop.
      wdata = $urandom;
      if (index <= CSR_LEN_3) begin
         wdata[LEN_BITS-1:0] = value[LEN_BITS-1:0];
      end else begin
         wdata[WEIGHT_BITS-1:0] = value[WEIGHT_BITS-1:0];
      end
      csr_access(1'b1, index, wdata, readback);
      sb.set_register(index, wdata);
      csr_access(1'b0, index, '0, readback);
      sb.compare_field("register readback", sb.register_value(index), readback);
   endtask

   task automatic configure(input int l0, l1, l2, l3, w0, w1, w2, w3);
      csr_write(CSR_LEN_0, l0);
      csr_write(CSR_LEN_1, l1);
      csr_write(CSR_LEN_2, l2);
      csr_write(CSR_LEN_3, l3);
      csr_write(CSR_WEIGHT_0, w0);
      csr_write(CSR_WEIGHT_1, w1);
      csr_write(CSR_WEIGHT_2, w2);
      csr_write(CSR_WEIGHT_3, w3);
      csr_psel <= 1'b0;
   endtask

   task automatic send_sample(input logic [SAMPLE_IN_BITS-1:0] sample);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until every pending result has been checked, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly a random walk so that prices wander across the averages, with some
   // repeats, jumps and rail values mixed in.
   function automatic logic [SAMPLE_IN_BITS-1:0] next_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) return SAMPLE_TOP;
      if (pick < 8) return '0;
      if (pick < 18) return SAMPLE_IN_BITS'($urandom);
      if (pick < 21) price = int'($urandom_range(0, int'(SAMPLE_TOP)));
      if (pick >= 30) price = price + int'($urandom_range(0, 2 * swing)) - swing;
      if (price < 0) price = 0;
      if (price > int'(SAMPLE_TOP)) price = int'(SAMPLE_TOP);
      return SAMPLE_IN_BITS'(price);
   endfunction

   task automatic random_samples(input int items, input int hold_at);
      for (int i = 0; i < items; i++) begin
         if (i == hold_at) long_hold = 1'b1;
         send_sample(next_sample());
      end
   endtask

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] readback;
      sb = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = int'(CSR_LEN_0); i <= int'(CSR_WEIGHT_3); i++) begin
         csr_access(1'b0, csr_index_type'(i), '0, readback);
         sb.compare_field("reset value", sb.register_value(csr_index_type'(i)), readback);
      end
      csr_psel <= 1'b0;

      // Short windows so that the opening run primes early and crosses both ways.
      configure(4, 3, 2, 1, 1, 2, 4, 8);
      foreach (OPENING_RUN[i]) send_sample(OPENING_RUN[i]);
      drain();

      // Back to the long default windows: priming is lost until the fill count reaches the first length.
      configure(200, 100, 50, 20, 1, 1, 1, 1);
      random_samples(400, -1);
      drain();

      swing = 1 << 18;
      configure(256, 255, 128, 1, 65535, 65535, 65535, 65535);
      random_samples(500, -1);
      drain();

      // Zero lengths act as one, oversized ones as the full ring, and the order is scrambled.
      swing = 4096;
      configure(0, 511, 300, 0, 0, 65535, 1, 32768);
      random_samples(300, -1);
      drain();

      configure(16, 8, 4, 2, 'h5555, 'hAAAA, 'h00FF, 'hFF00);
      random_samples(400, 100);
      drain();

      configure(3, 256, 2, 1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
      random_samples(200, -1);
      drain();

      quiet = 1'b1;
      configure(32, 24, 12, 3, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
      random_samples(300, -1);
      drain();

      if (sb.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
